@@ hdl/hsd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants of the Huffman stream decoder: phases, controller
// states, datapath operations and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int BYTE_W = 8;          // stream byte and symbol width
    localparam int VAL_W  = 9;          // node value: symbol or right-child link
    localparam int ENT_W  = VAL_W + 1;  // node entry: leaf flag over value
    localparam int LBC_W  = 4;          // leaf symbol bit counter
    localparam int BITS_W = 4;          // bits left in the current byte
    localparam int SKIP_W = 2;          // header skip counter

    localparam logic [LBC_W-1:0]  LEAF_LAST     = 4'd8;
    localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        PH_TREE,
        PH_SKIP,
        PH_DECODE,
        PH_ERROR
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TREE_BIT,
        ST_TREE_LINK,
        ST_SKIP,
        ST_DEC_READ,
        ST_DEC_EVAL,
        ST_FLUSH,
        ST_SINGLE,
        ST_ERROR_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TREE_BIT,
        OP_TREE_LINK,
        OP_SKIP,
        OP_DEC_READ,
        OP_DEC_STEP,
        OP_FLUSH,
        OP_SINGLE,
        OP_ERROR
    } t_op;

    typedef enum logic [1:0] {
        TR_CONT,    // bit consumed, tree still open
        TR_DONE,    // last leaf finished with an empty stack
        TR_LINK,    // leaf finished, popped parent needs its right link
        TR_OVFL     // node table or stack full
    } t_tree_res;

    typedef struct packed {
        t_tree_res tree_res;
        logic      last_bit;    // current bit is the last of the byte
        logic      bits_done;   // no bits left in the byte
        logic      root_leaf;   // tree is a single leaf
        logic      skip_le1;    // this skipped byte is the last one
        logic      out_free;    // output register can take a result
        logic      rd_leaf;     // node read data is a leaf
        logic      pend_valid;  // a decoded symbol waits for release
    } t_dp_status;

endpackage
`default_nettype wire

@@ hdl/huffman_stream_decoder_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_stream_decoder_top
// Byte-serial Huffman decoder. Each stream carries its code tree as a preorder
// bit string, followed by a fixed number of skipped bytes, then the code bits.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_byte, i_stream_start
//  out     | output    | o_out_valid / i_out_stall | o_symbol, o_last_of_byte,
//          |           |                           | o_tree_error
//
//  Sequence: one byte at a time. A tree byte takes one bit per cycle, plus
//  a link step when a finished leaf links its parent's right child through
//  the stack read. A skipped byte takes a single step, and a single-leaf
//  tree gives one symbol per bit while the output is free. A decode byte does
//  one node-table read, then one bit per cycle unless the output is held, then releases the held last symbol.
//  The node-table read port sets the decode pace: one read per bit.
//  Reset: synchronous, active low; returns to the tree phase, table and
//  stack contents are left as they are (every entry read is rewritten
//  first in the same stream).
//  Stalls: a single output register; a held output only pauses the sequencer
//  at the cycle that needs to load another result.
//
// ----------------------------------------------------------------------------
module huffman_stream_decoder_top
    import hsd_pkg::*;
#(
    parameter int MAX_NODES   = 511,
    parameter int STACK_DEPTH = 256,
    parameter int SKIP_BYTES  = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input byte channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic              i_stream_start,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [BYTE_W-1:0]      o_symbol,
    output logic                   o_last_of_byte,
    output logic                   o_tree_error
);

    t_op        w_op;
    t_dp_status w_status;

    // Sequencer: holds the stream phase, steps through the bits of a byte.
    hsd_ctrl #(
        .SKIP_BYTES (SKIP_BYTES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_stream_start (i_stream_start),
        .i_status       (w_status),
        .o_op           (w_op),
        .o_in_stall     (o_in_stall)
    );

    // Datapath: node table, pending-right stack, walk and output registers.
    hsd_datapath #(
        .MAX_NODES   (MAX_NODES),
        .SKIP_BYTES  (SKIP_BYTES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .i_out_stall    (i_out_stall),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_symbol       (o_symbol),
        .o_last_of_byte (o_last_of_byte),
        .o_tree_error   (o_tree_error)
    );

    // An accepted byte keeps the input stalled while it is worked on.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input not stalled after a byte transfer");

    // Error results always close their byte and carry a zero symbol.
    a_error_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tree_error) |-> (o_last_of_byte && (o_symbol == '0))
    ) else $error("malformed error result");

    // No decoded symbol is left held once the block is ready for a new byte.
    a_no_held_symbol_when_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_status.pend_valid
    ) else $error("held symbol lost at end of byte");

    // A held output result is never overwritten.
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !(w_op == OP_FLUSH || w_op == OP_SINGLE
                                           || w_op == OP_ERROR)
    ) else $error("output register loaded while stalled");

endmodule
`default_nettype wire

@@ hdl/hsd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_datapath
// Node table, pending-right stack, tree rebuild counters, tree walk registers
// and the output register. Acts on one operation code per cycle.
// ----------------------------------------------------------------------------
module hsd_datapath
    import hsd_pkg::*;
#(
    parameter int MAX_NODES   = 511,
    parameter int SKIP_BYTES  = 3,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_op               i_op,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic              i_stream_start,
    input  wire logic              i_out_stall,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    output logic [BYTE_W-1:0]      o_symbol,
    output logic                   o_last_of_byte,
    output logic                   o_tree_error
);

    localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW     = $clog2(MAX_NODES + 1);
    localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SDW     = $clog2(STACK_DEPTH + 1);

    // memories
    logic [ENT_W-1:0]   r_node_mem [MAX_NODES];
    logic [NODE_AW-1:0] r_stk_mem  [STACK_DEPTH];
    logic [ENT_W-1:0]   r_node_q;
    logic [NODE_AW-1:0] r_stk_q;

    // byte and rebuild state
    logic [BYTE_W-1:0]  r_byte;
    logic [BITS_W-1:0]  r_bits_left;
    logic [NCW-1:0]     r_nc;
    logic [SDW-1:0]     r_depth;
    logic [BYTE_W-1:0]  r_leaf_bits;
    logic [LBC_W-1:0]   r_lbc;
    logic [SKIP_W-1:0]  r_skip;
    logic               r_root_leaf;
    logic [BYTE_W-1:0]  r_root_sym;
    logic [NODE_AW-1:0] r_root_right;

    // walk state
    logic [NODE_AW-1:0] r_walk_n;
    logic [NODE_AW-1:0] r_walk_r;
    logic [NODE_AW-1:0] r_nx;
    logic               r_pend_valid;
    logic [BYTE_W-1:0]  r_pend_sym;

    // output register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_sym;
    logic               r_out_last;
    logic               r_out_err;

    logic               w_bit;
    logic [BYTE_W-1:0]  w_sym_done;
    logic [SDW-1:0]     w_depth_m1;
    t_tree_res          w_tree_res;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_rd_leaf;
    logic [NODE_AW-1:0] w_step_n;
    logic [NODE_AW-1:0] w_step_r;
    logic               w_node_we;
    logic [NODE_AW-1:0] w_node_wa;
    logic [ENT_W-1:0]   w_node_wd;
    logic [NODE_AW-1:0] w_node_ra;
    logic               w_stk_we;

    always_comb begin
        w_bit      = r_byte[BYTE_W-1];
        w_sym_done = {r_leaf_bits[BYTE_W-2:0], w_bit};
        w_depth_m1 = r_depth - SDW'(1);
        w_out_free = !r_out_valid || !i_out_stall;
        w_rd_leaf  = r_node_q[ENT_W-1];

        // operations that place a result in the output register
        w_out_load = (i_op == OP_FLUSH) || (i_op == OP_SINGLE) || (i_op == OP_ERROR)
                     || ((i_op == OP_DEC_STEP) && w_rd_leaf && r_pend_valid);

        w_tree_res = TR_CONT;
        if (r_lbc != '0) begin
            if (r_lbc == LEAF_LAST) begin
                w_tree_res = (r_depth == '0) ? TR_DONE : TR_LINK;
            end
        end else if (r_nc >= NCW'(MAX_NODES)) begin
            w_tree_res = TR_OVFL;
        end else if (!w_bit && (r_depth >= SDW'(STACK_DEPTH))) begin
            w_tree_res = TR_OVFL;
        end

        // walk position after the current decode step
        if (w_rd_leaf) begin
            w_step_n = '0;
            w_step_r = r_root_right;
        end else begin
            w_step_n = r_nx;
            w_step_r = r_node_q[NODE_AW-1:0];
        end

        w_node_we = 1'b0;
        w_node_wa = NODE_AW'(r_nc - NCW'(1));
        w_node_wd = {1'b1, VAL_W'(w_sym_done)};
        if (i_op == OP_TREE_BIT && r_lbc == LEAF_LAST) begin
            w_node_we = 1'b1;
        end
        if (i_op == OP_TREE_LINK) begin
            w_node_we = 1'b1;
            w_node_wa = r_stk_q;
            w_node_wd = {1'b0, VAL_W'(r_nc)};
        end

        w_stk_we = (i_op == OP_TREE_BIT) && (r_lbc == '0) && !w_bit
                   && (w_tree_res != TR_OVFL);

        // left child of an inner node is always the next index
        w_node_ra = r_nx;
        if (i_op == OP_DEC_READ) begin
            w_node_ra = w_bit ? r_walk_r : NODE_AW'(r_walk_n + NODE_AW'(1));
        end else if (i_op == OP_DEC_STEP) begin
            w_node_ra = r_byte[BYTE_W-2] ? w_step_r : NODE_AW'(w_step_n + NODE_AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_wa] <= w_node_wd;
        end
        r_node_q <= r_node_mem[w_node_ra];
        if (w_stk_we) begin
            r_stk_mem[r_depth[STK_AW-1:0]] <= NODE_AW'(r_nc);
        end
        r_stk_q <= r_stk_mem[w_depth_m1[STK_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_left  <= '0;
            r_nc         <= '0;
            r_depth      <= '0;
            r_leaf_bits  <= '0;
            r_lbc        <= '0;
            r_skip       <= '0;
            r_walk_n     <= '0;
            r_root_leaf  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                OP_LOAD: begin
                    r_byte      <= i_in_byte;
                    r_bits_left <= BITS_PER_BYTE;
                    if (i_stream_start) begin
                        r_nc        <= '0;
                        r_depth     <= '0;
                        r_leaf_bits <= '0;
                        r_lbc       <= '0;
                        r_skip      <= '0;
                        r_walk_n    <= '0;
                    end
                end
                OP_TREE_BIT: begin
                    r_byte      <= r_byte << 1;
                    r_bits_left <= r_bits_left - BITS_W'(1);
                    if (r_lbc != '0) begin
                        r_leaf_bits <= w_sym_done;
                        if (r_lbc == LEAF_LAST) begin
                            r_lbc <= '0;
                            if (r_nc == NCW'(1)) begin
                                r_root_sym <= w_sym_done;
                            end
                            if (r_depth != '0) begin
                                r_depth <= w_depth_m1;
                            end else begin
                                r_skip   <= SKIP_W'(SKIP_BYTES);
                                r_walk_n <= '0;
                                r_walk_r <= r_root_right;
                            end
                        end else begin
                            r_lbc <= r_lbc + LBC_W'(1);
                        end
                    end else if (w_tree_res != TR_OVFL) begin
                        if (r_nc == '0) begin
                            r_root_leaf <= w_bit;
                        end
                        if (w_bit) begin
                            r_lbc       <= LBC_W'(1);
                            r_leaf_bits <= '0;
                        end else begin
                            r_depth <= r_depth + SDW'(1);
                        end
                        r_nc <= r_nc + NCW'(1);
                    end
                end
                OP_TREE_LINK: begin
                    if (r_stk_q == '0) begin
                        r_root_right <= NODE_AW'(r_nc);
                    end
                end
                OP_SKIP: begin
                    if (r_skip != '0) begin
                        r_skip <= r_skip - SKIP_W'(1);
                    end
                end
                OP_DEC_READ: begin
                    r_nx <= w_node_ra;
                end
                OP_DEC_STEP: begin
                    r_nx        <= w_node_ra;
                    r_walk_n    <= w_step_n;
                    r_walk_r    <= w_step_r;
                    r_byte      <= r_byte << 1;
                    r_bits_left <= r_bits_left - BITS_W'(1);
                    if (w_rd_leaf) begin
                        // older symbol leaves; the newest waits to learn if it is last
                        if (r_pend_valid) begin
                            r_out_sym   <= r_pend_sym;
                            r_out_last  <= 1'b0;
                            r_out_err   <= 1'b0;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_sym   <= r_node_q[BYTE_W-1:0];
                    end
                end
                OP_FLUSH: begin
                    r_out_sym    <= r_pend_sym;
                    r_out_last   <= 1'b1;
                    r_out_err    <= 1'b0;
                    r_pend_valid <= 1'b0;
                end
                OP_SINGLE: begin
                    r_out_sym   <= r_root_sym;
                    r_out_last  <= (r_bits_left == BITS_W'(1));
                    r_out_err   <= 1'b0;
                    r_byte      <= r_byte << 1;
                    r_bits_left <= r_bits_left - BITS_W'(1);
                end
                OP_ERROR: begin
                    r_out_sym   <= '0;
                    r_out_last  <= 1'b1;
                    r_out_err   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_status.tree_res   = w_tree_res;
        o_status.last_bit   = (r_bits_left == BITS_W'(1));
        o_status.bits_done  = (r_bits_left == '0);
        o_status.root_leaf  = r_root_leaf;
        o_status.skip_le1   = (r_skip <= SKIP_W'(1));
        o_status.out_free   = w_out_free;
        o_status.rd_leaf    = w_rd_leaf;
        o_status.pend_valid = r_pend_valid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_out_sym;
    assign o_last_of_byte = r_out_last;
    assign o_tree_error   = r_out_err;

endmodule
`default_nettype wire

@@ hdl/hsd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_ctrl
// Phase register and per-byte sequencer. Issues one datapath operation per
// cycle from the phase and the datapath status.
// ----------------------------------------------------------------------------
module hsd_ctrl
    import hsd_pkg::*;
#(
    parameter int SKIP_BYTES = 3
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_stream_start,
    input  wire t_dp_status i_status,
    output t_op             o_op,
    output logic            o_in_stall
);

    t_state r_state;
    t_state n_state;
    t_phase r_phase;
    t_phase n_phase;
    t_phase w_eff_phase;
    logic   w_step_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_TREE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        w_eff_phase    = i_stream_start ? PH_TREE : r_phase;
        // a new leaf cannot push the held symbol out while the output is busy
        w_step_blocked = i_status.rd_leaf && i_status.pend_valid && !i_status.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_phase = w_eff_phase;
                    case (w_eff_phase)
                        PH_TREE:   n_state = ST_TREE_BIT;
                        PH_SKIP:   n_state = ST_SKIP;
                        PH_DECODE: n_state = i_status.root_leaf ? ST_SINGLE : ST_DEC_READ;
                        default:   n_state = ST_ERROR_OUT;
                    endcase
                end
            end
            ST_TREE_BIT: begin
                case (i_status.tree_res)
                    TR_OVFL: begin
                        n_phase = PH_ERROR;
                        n_state = ST_ERROR_OUT;
                    end
                    TR_DONE: begin
                        n_phase = (SKIP_BYTES == 0) ? PH_DECODE : PH_SKIP;
                        n_state = ST_IDLE;
                    end
                    TR_LINK: n_state = ST_TREE_LINK;
                    default: n_state = i_status.last_bit ? ST_IDLE : ST_TREE_BIT;
                endcase
            end
            ST_TREE_LINK: n_state = i_status.bits_done ? ST_IDLE : ST_TREE_BIT;
            ST_SKIP: begin
                n_phase = i_status.skip_le1 ? PH_DECODE : PH_SKIP;
                n_state = ST_IDLE;
            end
            ST_DEC_READ: n_state = ST_DEC_EVAL;
            ST_DEC_EVAL: begin
                if (!w_step_blocked && i_status.last_bit) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_status.pend_valid || i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SINGLE: begin
                if (i_status.out_free && i_status.last_bit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERROR_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_op       = OP_NONE;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op = OP_LOAD;
                end
            end
            ST_TREE_BIT:  o_op = OP_TREE_BIT;
            ST_TREE_LINK: o_op = OP_TREE_LINK;
            ST_SKIP:      o_op = OP_SKIP;
            ST_DEC_READ:  o_op = OP_DEC_READ;
            ST_DEC_EVAL: begin
                if (!w_step_blocked) begin
                    o_op = OP_DEC_STEP;
                end
            end
            ST_FLUSH: begin
                if (i_status.pend_valid && i_status.out_free) begin
                    o_op = OP_FLUSH;
                end
            end
            ST_SINGLE: begin
                if (i_status.out_free) begin
                    o_op = OP_SINGLE;
                end
            end
            ST_ERROR_OUT: begin
                if (i_status.out_free) begin
                    o_op = OP_ERROR;
                end
            end
            default: o_op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire
